FILE: hdl/ssm_pkg.sv
`timescale 1ns / 1ps

package ssm_pkg;

	// instruction classes on the input side
	typedef enum logic [3:0] {
		OP_OTHER = 4'd0,
		OP_LBZ   = 4'd1,
		OP_STB   = 4'd2,
		OP_LHZ   = 4'd3,
		OP_STH   = 4'd4,
		OP_LWZ   = 4'd5,
		OP_STW   = 4'd6,
		OP_LFS   = 4'd7,
		OP_STFS  = 4'd8,
		OP_LFD   = 4'd9,
		OP_STFD  = 4'd10,
		OP_LMW   = 4'd11,
		OP_STMW  = 4'd12
	} op_class_t;

	// access width codes: 1, 2, 4, 8 bytes
	typedef enum logic [1:0] {
		WC_1B = 2'd0,
		WC_2B = 2'd1,
		WC_4B = 2'd2,
		WC_8B = 2'd3
	} width_code_t;

	localparam logic [4:0] STACK_REG = 5'd1;
	localparam int unsigned SHOW_W = 16;   // counter width seen on the output
	localparam int unsigned SLOT_W = 8;    // covers up to 256 slots

	// query token walking the cell row; once done it carries the result
	typedef struct packed {
		logic              valid;
		logic              done;
		logic              stack;
		logic              store;
		width_code_t       wc;
		logic              fp;
		logic [15:0]       offset;
		logic              last;
		logic [SLOT_W-1:0] slot;
		logic              added;
		logic [SHOW_W-1:0] st;
		logic [SHOW_W-1:0] ld;
	} tok_t;

	function automatic logic op_is_mem(input logic [3:0] op);
		return (op inside {[OP_LBZ:OP_STMW]});
	endfunction

	function automatic width_code_t op_wc(input logic [3:0] op);
		width_code_t wc;
		case (op)
			OP_LBZ, OP_STB: wc = WC_1B;
			OP_LHZ, OP_STH: wc = WC_2B;
			OP_LFD, OP_STFD: wc = WC_8B;
			default: wc = WC_4B;
		endcase
		return wc;
	endfunction

	function automatic logic op_fp(input logic [3:0] op);
		return (op inside {[OP_LFS:OP_STFD]});
	endfunction

	function automatic logic op_store(input logic [3:0] op);
		return (op inside {OP_STB, OP_STH, OP_STW, OP_STFS, OP_STFD, OP_STMW});
	endfunction

endpackage

FILE: hdl/ssm_cell.sv
`timescale 1ns / 1ps

// one slot of the table; a token is consumed by the first empty or matching cell
module ssm_cell import ssm_pkg::*; #(
	parameter int unsigned CELL_IDX   = 0,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  tok_t tok_in,
	output tok_t tok_out
);

	logic                  vld_q;
	logic [15:0]           off_q;
	width_code_t           wc_q;
	logic                  fp_q;
	logic [COUNT_BITS-1:0] st_q, ld_q;
	tok_t                  tok_q;

	logic                  ins, hit;
	logic [COUNT_BITS-1:0] st_nx, ld_nx;
	tok_t                  nxt;

	function automatic logic [SHOW_W-1:0] show(input logic [COUNT_BITS-1:0] v);
		return (32'(v) > 32'hFFFF) ? 16'hFFFF : 16'(v);
	endfunction

	always_comb begin
		ins = 1'b0;
		hit = 1'b0;
		if (tok_in.valid && !tok_in.done) begin
			if (!vld_q)
				ins = 1'b1;
			else if (off_q == tok_in.offset && wc_q == tok_in.wc && fp_q == tok_in.fp)
				hit = 1'b1;
		end

		if (ins) begin
			st_nx = tok_in.store ? COUNT_BITS'(1) : '0;
			ld_nx = tok_in.store ? '0 : COUNT_BITS'(1);
		end else begin
			st_nx = (hit && tok_in.store && st_q != '1) ? st_q + 1'b1 : st_q;
			ld_nx = (hit && !tok_in.store && ld_q != '1) ? ld_q + 1'b1 : ld_q;
		end

		nxt = tok_in;
		if (ins || hit) begin
			nxt.done  = 1'b1;
			nxt.slot  = SLOT_W'(CELL_IDX);
			nxt.added = ins;
			nxt.st    = show(st_nx);
			nxt.ld    = show(ld_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= nxt;
			if (ins)
				vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ins) begin
				off_q <= tok_in.offset;
				wc_q  <= tok_in.wc;
				fp_q  <= tok_in.fp;
			end
			if (ins || hit) begin
				st_q <= st_nx;
				ld_q <= ld_nx;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: hdl/stack_slot_mapper.sv
`timescale 1ns / 1ps

// Stack slot mapper. Each input word is one decoded instruction; each gives exactly one
// output word. r1-relative loads and stores are matched by (offset, width, float) against
// a row of MAX_SLOTS slot cells; a miss appends a new slot in the first empty cell, a
// full table sets table_full. Every word, stack reference or not, walks the cell row as
// a token, one cell per cycle while the row is not held; m_tvalid rises once the token
// has left the last cell and the output register has loaded. One word is in the row at
// a time; s_tready comes back the cycle after the previous result has left the row, even
// while that result still waits in the output register, so no new word is taken while
// one is still in the row. Counters saturate at 2^COUNT_BITS-1 and show as at most
// 65535. The table is cleared only by reset.
module stack_slot_mapper import ssm_pkg::*; #(
	parameter int unsigned MAX_SLOTS  = 64,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] op_class, [8:4] base_reg, [24:9] displacement, [31:25] zero
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,     // last_insn
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] is_stack_ref, [6:1] slot_number, [7] newly_added, [8] table_full,
	// [24:9] slot_stores, [40:25] slot_loads, [47:41] slots_in_use
	output logic [47:0] m_tdata,
	output logic        m_tlast      // end_of_stream
);

	localparam int unsigned USED_W = $clog2(MAX_SLOTS + 1);

	logic [3:0]  in_op;
	logic [4:0]  in_base;
	logic [15:0] in_disp;
	logic        in_stack;
	logic        accept, adv, ld_out;

	logic              walk_q;
	tok_t              inj_q;
	tok_t              exit_tok;
	logic [USED_W-1:0] used_q, used_nx;
	tok_t              chain [0:MAX_SLOTS];

	// output register
	logic        out_stack_q, out_added_q, out_full_q, out_last_q;
	logic [5:0]  out_slot_q;
	logic [15:0] out_st_q, out_ld_q;
	logic [6:0]  out_used_q;

	assign in_op    = s_tdata[3:0];
	assign in_base  = s_tdata[8:4];
	assign in_disp  = s_tdata[24:9];
	assign in_stack = op_is_mem(in_op) && in_base == STACK_REG;

	assign s_tready = !walk_q;
	assign accept   = s_tvalid && s_tready;

	assign exit_tok = chain[MAX_SLOTS];
	assign ld_out   = exit_tok.valid && (!m_tvalid || m_tready);
	// hold the row while a finished token cannot leave it
	assign adv      = !exit_tok.valid || ld_out;
	assign used_nx  = used_q + USED_W'(exit_tok.added);

	assign chain[0] = inj_q;

	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
		ssm_cell #(
			.CELL_IDX   (i),
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q   <= 1'b0;
			inj_q    <= '0;
			used_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (accept) begin
				walk_q       <= 1'b1;
				inj_q.valid  <= 1'b1;
				// non-stack words ride the row already finished
				inj_q.done   <= !in_stack;
				inj_q.stack  <= in_stack;
				inj_q.store  <= op_store(in_op);
				inj_q.wc     <= op_wc(in_op);
				inj_q.fp     <= op_fp(in_op);
				inj_q.offset <= in_disp;
				inj_q.last   <= s_tlast;
				inj_q.slot   <= '0;
				inj_q.added  <= 1'b0;
				inj_q.st     <= '0;
				inj_q.ld     <= '0;
			end else if (adv) begin
				inj_q.valid <= 1'b0;
			end

			if (ld_out) begin
				walk_q   <= 1'b0;
				used_q   <= used_nx;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_stack_q <= exit_tok.stack;
			out_full_q  <= exit_tok.stack && !exit_tok.done;
			out_added_q <= exit_tok.added;
			out_slot_q  <= exit_tok.done ? 6'(exit_tok.slot) : '0;
			out_st_q    <= exit_tok.st;
			out_ld_q    <= exit_tok.ld;
			out_used_q  <= 7'(used_nx);
			out_last_q  <= exit_tok.last;
		end
	end

	assign m_tdata = {out_used_q, out_ld_q, out_st_q, out_full_q, out_added_q,
		out_slot_q, out_stack_q};
	assign m_tlast = out_last_q;

	a_no_stray_token: assert property (@(posedge clk) disable iff (!arst_n)
		!walk_q |-> !exit_tok.valid)
		else $error("token in cell row with no word in flight");

	a_accept_walks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> walk_q && inj_q.valid)
		else $error("accepted word not injected");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= MAX_SLOTS)
		else $error("slot count beyond table size");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out && exit_tok.added |=> used_q == $past(used_q) + 1'b1)
		else $error("slot count not bumped on insert");

	a_added_stack: assert property (@(posedge clk) disable iff (!arst_n)
		exit_tok.valid && exit_tok.added |-> exit_tok.stack && exit_tok.done)
		else $error("slot added for a non-stack word");

endmodule

FILE: test/stack_slot_mapper_tb.sv
`timescale 1ns / 1ps

// Stack slot mapper testbench.
// Words go in over the slave stream, one decoded instruction each; every accepted word
// gives one result word on the master stream. A scoreboard model of the slot table runs
// on every accepted input word and queues its prediction or a typed row's expectation.
// Results are popped and compared in order. A short directed table runs first, then
// three random phases with different back-pressure mixes.
module stack_slot_mapper_tb;
	import ssm_pkg::*;

	localparam int unsigned SLOTS        = 64;
	localparam int unsigned CNT_CAP      = 65535;   // 2^COUNT_BITS - 1
	localparam int unsigned RAND_ITEMS   = 500;
	localparam int unsigned HOLD_CYCLES  = 300;     // long receiver hold-off
	localparam int unsigned DRAIN_CYCLES = 80;      // idle wait after the final drain
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned MAX_REPORTS  = 10;

	// opcodes the block treats as non-memory
	localparam logic [3:0] OP_SPARE_LO = 4'd13;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;

	// result word as seen on {m_tlast, m_tdata}, MSB first
	typedef struct packed {
		logic        eos;
		logic [6:0]  in_use;
		logic [15:0] loads;
		logic [15:0] stores;
		logic        full;
		logic        added;
		logic [5:0]  slot;
		logic        stack;
	} slot_res_t;

	typedef struct {
		logic [3:0]  op;
		logic [4:0]  base;
		logic [15:0] disp;
		logic        last;
		logic        typed;   // res below is the expectation, not the model's
		slot_res_t   res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // [3:0] op_class, [8:4] base_reg, [24:9] displacement
	logic        s_tlast;    // last_insn
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;    // [0] stack, [6:1] slot, [7] added, [8] full, [24:9] stores,
	                         // [40:25] loads, [47:41] slots_in_use
	logic        m_tlast;    // end_of_stream

	stack_slot_mapper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// scoreboard copy of the slot table
	logic [15:0]  slot_off [SLOTS];
	width_code_t  slot_wc  [SLOTS];
	logic         slot_fp  [SLOTS];
	int unsigned  slot_st  [SLOTS];
	int unsigned  slot_ld  [SLOTS];
	int unsigned  n_slots;

	slot_res_t    pending_q [$];     // predicted results, oldest first
	logic [3:0]   seen_op   [$];     // stack accesses issued so far, for reuse
	logic [15:0]  seen_disp [$];
	dir_row_t     dir_tab   [$];

	// expectation override travels with the word, driven in the same step as s_tdata
	logic         cur_typed;
	slot_res_t    cur_res;

	int unsigned  tx_idle_pct, rx_idle_pct;
	int unsigned  rx_hold;
	int unsigned  cyc;
	int unsigned  err_cnt, n_checked, n_stack, n_added, n_full, n_hits;
	slot_res_t    want, got, model_res;

	// Slot lookup: match on (offset, width, float), else append; bump the store or
	// load counter with saturation. Non-r1 or non-memory words leave the table alone.
	function automatic slot_res_t map_access(logic [3:0] op, logic [4:0] base,
			logic [15:0] disp, logic last);
		slot_res_t   r;
		width_code_t wc;
		logic        mem, fp, wr;
		int          hit;
		r   = '0;
		mem = 1'b1;
		fp  = 1'b0;
		wr  = 1'b0;
		wc  = WC_4B;
		hit = -1;
		case (op)
			OP_LBZ:  wc = WC_1B;
			OP_STB:  begin wc = WC_1B; wr = 1'b1; end
			OP_LHZ:  wc = WC_2B;
			OP_STH:  begin wc = WC_2B; wr = 1'b1; end
			OP_LWZ, OP_LMW: wc = WC_4B;
			OP_STW, OP_STMW: wr = 1'b1;
			OP_LFS:  fp = 1'b1;
			OP_STFS: begin fp = 1'b1; wr = 1'b1; end
			OP_LFD:  begin wc = WC_8B; fp = 1'b1; end
			OP_STFD: begin wc = WC_8B; fp = 1'b1; wr = 1'b1; end
			default: mem = 1'b0;
		endcase
		if (mem && base == STACK_REG) begin
			r.stack = 1'b1;
			for (int k = 0; k < n_slots; k++)
				if (hit < 0 && slot_off[k] == disp && slot_wc[k] == wc && slot_fp[k] == fp)
					hit = k;
			if (hit < 0 && n_slots < SLOTS) begin
				hit           = n_slots;
				slot_off[hit] = disp;
				slot_wc[hit]  = wc;
				slot_fp[hit]  = fp;
				slot_st[hit]  = 0;
				slot_ld[hit]  = 0;
				n_slots++;
				r.added = 1'b1;
			end
			if (hit < 0) begin
				r.full = 1'b1;
			end else begin
				if (wr) begin
					if (slot_st[hit] < CNT_CAP) slot_st[hit]++;
				end else if (slot_ld[hit] < CNT_CAP) begin
					slot_ld[hit]++;
				end
				r.slot   = 6'(hit);
				r.stores = 16'(slot_st[hit]);
				r.loads  = 16'(slot_ld[hit]);
			end
		end
		r.in_use = 7'(n_slots);
		r.eos    = last;
		return r;
	endfunction

	function automatic slot_res_t mk_res(bit stack, int unsigned slot, bit added, bit full,
			int unsigned st, int unsigned ld, int unsigned used, bit eos);
		slot_res_t r;
		r = '{eos: eos, in_use: 7'(used), loads: 16'(ld), stores: 16'(st), full: full,
			added: added, slot: 6'(slot), stack: stack};
		return r;
	endfunction

	task automatic add_row(logic [3:0] op, logic [4:0] base, logic [15:0] disp,
			logic last, logic typed, slot_res_t res);
		dir_row_t row;
		row = '{op: op, base: base, disp: disp, last: last, typed: typed, res: res};
		dir_tab.push_back(row);
	endtask

	// one result word failed to match; only the first few get printed
	task automatic flag_mismatch(string what);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Scoreboard: predict on input acceptance, compare on output acceptance.
	// Both handshakes are sampled with pre-edge values.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n && s_tvalid && s_tready) begin
			model_res = map_access(s_tdata[3:0], s_tdata[8:4], s_tdata[24:9], s_tlast);
			pending_q.push_back(cur_typed ? cur_res : model_res);
		end
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got = {m_tlast, m_tdata};
			if (pending_q.size() == 0) begin
				flag_mismatch($sformatf("result %h with nothing outstanding", got));
			end else begin
				want = pending_q.pop_front();
				n_checked++;
				if (want.stack) n_stack++;
				if (want.added) n_added++;
				if (want.full) n_full++;
				if (want.stack && !want.added && !want.full) n_hits++;
				if (got !== want)
					flag_mismatch($sformatf({"stack %b/%b slot %0d/%0d added %b/%b ",
						"full %b/%b st %0d/%0d ld %0d/%0d used %0d/%0d eos %b/%b (exp/got)"},
						want.stack, got.stack, want.slot, got.slot, want.added, got.added,
						want.full, got.full, want.stores, got.stores, want.loads, got.loads,
						want.in_use, got.in_use, want.eos, got.eos));
			end
		end
	end

	// Receiver: random stalls at rx_idle_pct, plus a long hold when rx_hold is loaded.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Offer one word, with an optional gap first; returns after the accepting edge.
	// Gaps are short or long with equal odds; long ones can span a good part of the row walk.
	task automatic send_word(logic [3:0] op, logic [4:0] base, logic [15:0] disp,
			logic last, logic typed, slot_res_t res);
		int unsigned gap;
		if ($urandom_range(99) < tx_idle_pct) begin
			gap = $urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(4, 80);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= {7'd0, disp, base, op};
		s_tlast   <= last;
		cur_typed <= typed;
		cur_res   <= res;
		do @(posedge clk); while (!s_tready);
	endtask

	// Sender stops until every predicted result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	// Random word: mostly r1 accesses, many reusing an earlier (op, offset) so slots
	// get hit; load/store partners share a slot key. About one in eight is noise.
	task automatic random_word();
		logic [3:0]  op;
		logic [4:0]  base;
		logic [15:0] disp;
		int unsigned pick, k;
		pick = $urandom_range(99);
		disp = 16'($urandom);
		if (pick < 12) begin
			if ($urandom_range(1)) begin
				op   = $urandom_range(2) == 0 ? OP_OTHER
					: 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
				base = 5'($urandom);
			end else begin
				op = 4'($urandom_range(OP_STMW, OP_LBZ));
				do base = 5'($urandom); while (base == STACK_REG);
			end
		end else begin
			base = STACK_REG;
			if (seen_op.size() > 0 && pick >= 40) begin
				k    = $urandom_range(seen_op.size() - 1);
				op   = seen_op[k];
				disp = seen_disp[k];
				// flip load <-> store of the same width
				if ($urandom_range(1)) op = op[0] ? op + 4'd1 : op - 4'd1;
			end else begin
				op = 4'($urandom_range(OP_STMW, OP_LBZ));
				seen_op.push_back(op);
				seen_disp.push_back(disp);
			end
		end
		send_word(op, base, disp, $urandom_range(9) == 0, 1'b0, '0);
	endtask

	// Watchdog
	initial begin
		while (cyc < CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		cur_typed   = 1'b0;
		cur_res     = '0;
		n_slots     = 0;
		rx_hold     = 0;
		cyc         = 0;
		err_cnt     = 0;
		n_checked   = 0;
		n_stack     = 0;
		n_added     = 0;
		n_full      = 0;
		n_hits      = 0;
		tx_idle_pct = 9;
		rx_idle_pct = 47;

		// Directed rows. Typed rows: pass-over cases (non-memory, spare codes, wrong
		// base) and the first two accesses after reset. The rest go through the model:
		// lmw folding onto the lwz slot, float vs integer at the same offset, offset
		// extremes, every op class, end-of-stream marks.
		add_row(OP_OTHER,    5'd1,  16'h0000, 1'b0, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(OP_SPARE_LO, 5'd1,  16'h8000, 1'b0, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(OP_SPARE_HI, 5'd31, 16'hFFFF, 1'b1, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0, 1));
		add_row(OP_LWZ,      5'd0,  16'h0000, 1'b0, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(OP_STFD,     5'd31, 16'h7FFF, 1'b0, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(OP_STW,      5'd1,  16'h7FFF, 1'b0, 1'b1, mk_res(1, 0, 1, 0, 1, 0, 1, 0));
		add_row(OP_LWZ,      5'd1,  16'h7FFF, 1'b0, 1'b1, mk_res(1, 0, 0, 0, 1, 1, 1, 0));
		add_row(OP_LMW,      5'd1,  16'h7FFF, 1'b0, 1'b0, '0);
		add_row(OP_STMW,     5'd1,  16'h7FFF, 1'b0, 1'b0, '0);
		add_row(OP_LFS,      5'd1,  16'h7FFF, 1'b0, 1'b0, '0);
		add_row(OP_STFS,     5'd1,  16'h7FFF, 1'b0, 1'b0, '0);
		add_row(OP_LFD,      5'd1,  16'h8000, 1'b0, 1'b0, '0);
		add_row(OP_STFD,     5'd1,  16'h8000, 1'b0, 1'b0, '0);
		add_row(OP_LBZ,      5'd1,  16'h0000, 1'b0, 1'b0, '0);
		add_row(OP_STB,      5'd1,  16'h0000, 1'b0, 1'b0, '0);
		add_row(OP_LHZ,      5'd1,  16'h0000, 1'b0, 1'b0, '0);
		add_row(OP_STH,      5'd1,  16'hFFFF, 1'b0, 1'b0, '0);
		add_row(OP_STH,      5'd1,  16'hFFFF, 1'b1, 1'b0, '0);
		add_row(OP_LWZ,      5'd2,  16'h7FFF, 1'b0, 1'b0, '0);
		add_row(OP_STW,      5'd1,  16'h5555, 1'b0, 1'b0, '0);
		add_row(OP_LWZ,      5'd1,  16'hAAAA, 1'b1, 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i].op, dir_tab[i].base, dir_tab[i].disp, dir_tab[i].last,
				dir_tab[i].typed, dir_tab[i].res);
		drain();

		// phase A: light sender gaps, heavy receiver stalls; one long hold-off partway
		// in while the sender keeps offering, so s_tready has to drop
		for (int i = 0; i < RAND_ITEMS / 3; i++) begin
			if (i == RAND_ITEMS / 12) rx_hold = HOLD_CYCLES;
			random_word();
		end
		drain();

		// phase B: the other way round
		tx_idle_pct = 47;
		rx_idle_pct = 9;
		for (int i = 0; i < RAND_ITEMS / 3; i++)
			random_word();
		drain();

		// phase C: back to back, no stalls
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < RAND_ITEMS - 2 * (RAND_ITEMS / 3); i++)
			random_word();
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d words: %0d r1 accesses (%0d new slots, %0d hits, %0d table full)",
			n_checked, n_stack, n_added, n_hits, n_full);
		$display("%0d words passed over; %0d slots in use at the end; %0d mismatches",
			n_checked - n_stack, n_slots, err_cnt);
		if (err_cnt == 0 && pending_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
